// File: rtl/fcw_pkg.sv
package fcw_pkg;

    // request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // fat12 end-of-chain marker and register reset
    localparam logic [11:0] END_MARK       = 12'hFF8;
    localparam logic [13:0] FAT_SIZE_RESET = 14'd4608;

    typedef struct packed {
        logic        operation;
        logic [12:0] byte_address;
        logic [7:0]  byte_data;
        logic [11:0] start_cluster;
        logic [6:0]  cluster_limit;
    } req_item_t;

    typedef struct packed {
        logic [11:0] cluster;
        logic        last;
        logic [1:0]  status;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic write_byte;
        logic load_req;
        logic issue_lo;
        logic issue_hi;
        logic load_out;
        logic sel_special;
        logic advance;
    } fcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_walk;
        logic special;
        logic last;
        logic out_free;
    } fcw_sts_t;

endpackage

// File: rtl/fcw_ram.sv
module fcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read that holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/fcw_ctrl.sv
module fcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  fcw_pkg::fcw_sts_t sts,
    output fcw_pkg::fcw_cmd_t cmd
);
    import fcw_pkg::*;

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        START = 5'b00010,
        RD_LO = 5'b00100,
        RD_HI = 5'b01000,
        CALC  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (sts.req_walk)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = START;
                    end
                    else
                    begin
                        cmd.write_byte = 1'b1;
                    end
                end
            end
            START:
            begin
                if (sts.special)
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_out    = 1'b1;
                        cmd.sel_special = 1'b1;
                        state_next      = IDLE;
                    end
                end
                else
                begin
                    state_next = RD_LO;
                end
            end
            RD_LO:
            begin
                cmd.issue_lo = 1'b1;
                state_next   = RD_HI;
            end
            RD_HI:
            begin
                cmd.issue_hi = 1'b1;
                state_next   = CALC;
            end
            CALC:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.last)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = RD_LO;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    // the high byte read always follows the low byte read
    a_hi_after_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RD_HI) |-> $past(state_reg == RD_LO))
        else $error("high byte read without low byte read");

endmodule

// File: rtl/fcw_datapath.sv
module fcw_datapath #(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_CHAIN = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fcw_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fcw_pkg::rsp_item_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        cfg_data,
    input  fcw_pkg::fcw_cmd_t  cmd,
    output fcw_pkg::fcw_sts_t  sts
);
    import fcw_pkg::*;

    localparam int AW = $clog2(FAT_BYTES);
    localparam logic [6:0] CHAIN_CAP = 7'(MAX_CHAIN);

    logic [13:0] fat_size_reg;
    logic [11:0] cur_reg;
    logic [6:0]  limit_reg;
    logic [6:0]  count_reg;
    logic [7:0]  lo_reg;
    logic        rd_ok_reg;
    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg;

    logic [12:0]   pos;
    logic [12:0]   pos_hi;
    logic [12:0]   rd_pos;
    logic [AW-1:0] ram_addr;
    logic          ram_re;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic [7:0]    hi_byte;
    logic [11:0]   entry;
    logic          stop;
    logic          bad_first;
    logic [6:0]    limit_sat;

    assign cfg_ready = 1'b1;

    // config register transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_size_reg <= FAT_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            fat_size_reg <= cfg_data;
        end
    end

    // byte position of the current entry
    assign pos    = 13'(cur_reg) + 13'(cur_reg >> 1);
    assign pos_hi = pos + 13'd1;
    assign rd_pos = cmd.issue_hi ? pos_hi : pos;

    // ram port: byte loads in idle, entry reads during a walk
    assign ram_we   = cmd.write_byte && (32'(req.byte_address) < FAT_BYTES);
    assign ram_re   = cmd.issue_lo || cmd.issue_hi;
    assign ram_addr = cmd.write_byte ? AW'(req.byte_address) : AW'(rd_pos);

    fcw_ram #(
        .WIDTH (8),
        .DEPTH (FAT_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (req.byte_data),
        .rdata (ram_rdata)
    );

    // limit saturation
    assign limit_sat = (req.cluster_limit > CHAIN_CAP) ? CHAIN_CAP : req.cluster_limit;

    // walk state and byte capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cur_reg   <= req.start_cluster;
            limit_reg <= limit_sat;
            count_reg <= '0;
        end
        else if (cmd.advance)
        begin
            cur_reg   <= entry;
            count_reg <= count_reg + 7'd1;
        end
        if (cmd.issue_lo)
        begin
            rd_ok_reg <= 32'(pos) < FAT_BYTES;
        end
        if (cmd.issue_hi)
        begin
            lo_reg    <= rd_ok_reg ? ram_rdata : 8'd0;
            rd_ok_reg <= 32'(pos_hi) < FAT_BYTES;
        end
    end

    // next entry from the two bytes
    assign hi_byte = rd_ok_reg ? ram_rdata : 8'd0;
    assign entry   = cur_reg[0] ? {hi_byte, lo_reg[7:4]} : {hi_byte[3:0], lo_reg};

    // end of walk tests
    assign stop = (entry == 12'd0) || (entry >= END_MARK)
               || ({2'b00, entry} > fat_size_reg)
               || (({1'b0, count_reg} + 8'd1) >= {1'b0, limit_reg});

    assign bad_first = (cur_reg == 12'd0) || (fat_size_reg == 14'd0);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.sel_special)
            begin
                rsp_reg.cluster <= 12'd0;
                rsp_reg.last    <= 1'b1;
                rsp_reg.status  <= bad_first ? ST_INVALID : ST_EMPTY;
            end
            else
            begin
                rsp_reg.cluster <= cur_reg;
                rsp_reg.last    <= stop;
                rsp_reg.status  <= ST_VALID;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status to the controller
    assign sts.req_walk = (req.operation == OP_WALK);
    assign sts.special  = bad_first || (limit_reg == 7'd0);
    assign sts.last     = stop;
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

    // a chain result never goes past the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !cmd.sel_special) |-> (count_reg < limit_reg))
        else $error("chain result beyond the limit");

    // empty and invalid results always close the walk
    a_special_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_VALID)) |-> rsp.last)
        else $error("special result not marked last");

endmodule

// File: rtl/fat12_cluster_chain_walker.sv
// byte load: one cycle per transfer, no result
// walk: after the request transfer a start check, then for each cluster a low byte read, a high byte read
// and entry decode (two reads on the single table ram port); a result waits while the output is stalled
// empty or invalid walk: one result, loaded from the start check once the output register is free
// reset clears the controller and the output valid flag, and sets the fat size register to 4608;
// the table itself is not cleared and holds unknown bytes until loaded
module fat12_cluster_chain_walker #(
    parameter int FAT_BYTES = 8192,
    parameter int MAX_CHAIN = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  fcw_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fcw_pkg::rsp_item_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        cfg_data
);
    import fcw_pkg::*;

    fcw_cmd_t cmd;
    fcw_sts_t sts;

    // sequencer
    fcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table, walk registers and output register
    fcw_datapath #(
        .FAT_BYTES (FAT_BYTES),
        .MAX_CHAIN (MAX_CHAIN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
